// File: src/qgb_pkg.sv
// ----------------------------------------------------------------------------
// qgb_pkg: shared types, constants and rotation table builder
// Gate codes, Q1.30 coefficient constants, control struct and the constant
// function that builds the cos/sin entries of the phase rotation table.
// ----------------------------------------------------------------------------
`default_nettype none

package qgb_pkg;

	localparam int QUBITS_DEF    = 64;
	localparam int AMP_BITS_DEF  = 32;
	localparam int ROT_K_MAX_DEF = 32;

	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = 30;

	localparam logic signed [COEF_W-1:0] COEF_ONE       = 32'sh4000_0000;
	localparam logic signed [COEF_W-1:0] COEF_NEG_ONE   = 32'shC000_0000;
	localparam logic signed [COEF_W-1:0] COEF_ZERO      = 32'sh0000_0000;
	localparam logic signed [COEF_W-1:0] COEF_INV_SQRT2 = 32'sd759250125;

	localparam logic [63:0] PI_QUARTER_Q64 = 64'hC90F_DAA2_2168_C235;
	localparam int SERIES_TERMS = 12;

	// (2n)(2n+1) for n = 1..12
	localparam logic [63:0] SIN_DIV [SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};
	// (2n-1)(2n) for n = 2..13
	localparam logic [63:0] COS_DIV [SERIES_TERMS] = '{
		64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
		64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
	};

	typedef enum logic [3:0] {
		GATE_H       = 4'd0,
		GATE_X       = 4'd1,
		GATE_Y       = 4'd2,
		GATE_Z       = 4'd3,
		GATE_S       = 4'd4,
		GATE_T       = 4'd5,
		GATE_RK      = 4'd6,
		GATE_SWAP    = 4'd7,
		GATE_CX      = 4'd8,
		GATE_CY      = 4'd9,
		GATE_CZ      = 4'd10,
		GATE_CS      = 4'd11,
		GATE_CRK     = 4'd12,
		GATE_TOFFOLI = 4'd13,
		GATE_FREDKIN = 4'd14
	} gate_t;

	typedef struct packed {
		logic dual;
		logic neg;
	} qgb_ctl_t;

	function automatic logic [63:0] mulhi(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64];
	endfunction

	// {cos, sin} in Q1.30 for exp(i*pi/2^(k-1))
	function automatic logic [2*COEF_W-1:0] rot_entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s_sum;
		logic [63:0] c_sum;
		logic [63:0] s_rnd;
		logic [63:0] c_rnd;
		logic signed [COEF_W-1:0] cr;
		logic signed [COEF_W-1:0] ci;
		if (k <= 1) begin
			return {COEF_NEG_ONE, COEF_ZERO};
		end
		if (k == 2) begin
			return {COEF_ZERO, COEF_ONE};
		end
		x = PI_QUARTER_Q64 >> (k - 3);
		x2 = mulhi(x, x);
		t = x;
		s_sum = x;
		for (int j = 0; j < SERIES_TERMS; j++) begin
			t = mulhi(t, x2) / SIN_DIV[j];
			if (j % 2 == 0) begin
				s_sum = s_sum - t;
			end else begin
				s_sum = s_sum + t;
			end
		end
		t = x2 >> 1;
		c_sum = t;
		for (int j = 0; j < SERIES_TERMS; j++) begin
			t = mulhi(t, x2) / COS_DIV[j];
			if (j % 2 == 0) begin
				c_sum = c_sum - t;
			end else begin
				c_sum = c_sum + t;
			end
		end
		s_rnd = (s_sum + 64'h2_0000_0000) >> 34;
		c_rnd = (c_sum + 64'h2_0000_0000) >> 34;
		ci = signed'(s_rnd[COEF_W-1:0]);
		cr = COEF_ONE - signed'(c_rnd[COEF_W-1:0]);
		return {cr, ci};
	endfunction

endpackage

`default_nettype wire

// File: src/quantum_gate_basis_amplitude_update_unit.sv
// ----------------------------------------------------------------------------
// quantum_gate_basis_amplitude_update_unit: sparse register gate pipeline
// Applies one quantum gate to one basis/amplitude entry of a sparse register.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one register entry per item: gate code, qubit indices,
//   rotation order, basis pattern and complex Q1.(AMP_BITS-2) amplitude.
//   m_* returns the updated entries; m_tlast marks the final entry of an
//   input item. Hadamard gives two entries (same basis, then the flipped
//   one), every other gate gives one.
//   An item is decoded into stage 1 at the accepting edge, then passes
//   through partial products (stage 2), rounding (stage 3), and add and
//   saturate into the output register before it shows on m_*.
//   Throughput: one item per cycle while m_tready is high; a Hadamard holds
//   the output register for its second entry and stalls the input meanwhile.
//   Every gate runs through the same complex multiply of the amplitude by
//   a Q1.30 coefficient, eight partial-product multipliers in one stage.
//   When m_tready is low the stages fill up one by one and s_tready drops
//   once no stage is free; nothing is lost or repeated.
//   Reset clears all valid bits; no item is in flight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quantum_gate_basis_amplitude_update_unit #(
	parameter int QUBITS    = qgb_pkg::QUBITS_DEF,
	parameter int AMP_BITS  = qgb_pkg::AMP_BITS_DEF,
	parameter int ROT_K_MAX = qgb_pkg::ROT_K_MAX_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// func, qubit_a, qubit_b, qubit_c, rot_order, basis_in, amp_re_in, amp_im_in
	input  logic [((92+2*AMP_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// basis_out, amp_re_out, amp_im_out
	output logic [((64+2*AMP_BITS+7)/8)*8-1:0]      m_tdata,
	output logic                                    m_tlast
);

	localparam int OUT_TW = ((64 + 2*AMP_BITS + 7) / 8) * 8;
	localparam int CW     = qgb_pkg::COEF_W;
	localparam int FRAC   = qgb_pkg::COEF_FRAC;
	localparam int EXT_W  = (AMP_BITS > FRAC) ? AMP_BITS : FRAC + 1;
	localparam int HI_W   = EXT_W - FRAC;
	localparam int LO_PW  = FRAC + 1 + CW;
	localparam int HI_PW  = HI_W + CW;
	localparam int PW     = EXT_W + 3;
	localparam int SW     = PW + 1;

	localparam int F_RE = 92;
	localparam int F_IM = 92 + AMP_BITS;

	localparam logic signed [LO_PW-1:0] RND_HALF = LO_PW'(64'd1 << (FRAC - 1));
	localparam logic signed [SW-1:0] SAT_HI =
		{{(SW-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
	localparam logic signed [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

	// decode
	logic [QUBITS-1:0]       dec_basis, dec_alt;
	logic signed [CW-1:0]    dec_cr, dec_ci;
	qgb_pkg::qgb_ctl_t       dec_ctl;

	qgb_decode #(
		.QUBITS    (QUBITS),
		.ROT_K_MAX (ROT_K_MAX)
	) u_decode (
		.func      (s_tdata[3:0]),
		.qubit_a   (s_tdata[9:4]),
		.qubit_b   (s_tdata[15:10]),
		.qubit_c   (s_tdata[21:16]),
		.rot_order (s_tdata[27:22]),
		.basis     (s_tdata[28+QUBITS-1:28]),
		.basis_out (dec_basis),
		.basis_alt (dec_alt),
		.coef_re   (dec_cr),
		.coef_im   (dec_ci),
		.ctl       (dec_ctl)
	);

	// stage registers
	logic                        valid_s1, valid_s2, valid_s3;
	logic [QUBITS-1:0]           basis_s1, basis_s2, basis_s3;
	logic [QUBITS-1:0]           alt_s1, alt_s2, alt_s3;
	qgb_pkg::qgb_ctl_t           ctl_s1, ctl_s2, ctl_s3;
	logic signed [CW-1:0]        cr_s1, ci_s1;
	logic signed [AMP_BITS-1:0]  re_s1, im_s1;
	logic signed [LO_PW-1:0]     plo_s2 [4];
	logic signed [HI_PW-1:0]     phi_s2 [4];
	logic signed [PW-1:0]        prod_s3 [4];

	logic                        out_valid_q, pend_q, last_q;
	logic [QUBITS-1:0]           basis_q, basis2_q;
	logic signed [AMP_BITS-1:0]  re_q, im_q, re2_q, im2_q;

	logic en_s1, en_s2, en_s3, out_en;

	assign out_en   = !out_valid_q || (m_tready && !pend_q);
	assign en_s3    = !valid_s3 || out_en;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;

	// stage 1: decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			basis_s1 <= dec_basis;
			alt_s1   <= dec_alt;
			ctl_s1   <= dec_ctl;
			cr_s1    <= dec_cr;
			ci_s1    <= dec_ci;
			re_s1    <= signed'(s_tdata[F_RE+AMP_BITS-1:F_RE]);
			im_s1    <= signed'(s_tdata[F_IM+AMP_BITS-1:F_IM]);
		end
	end

	// stage 2: split partial products
	logic signed [EXT_W-1:0] re_ext, im_ext;
	logic signed [EXT_W-1:0] a_lane [4];
	logic signed [CW-1:0]    c_lane [4];
	logic signed [LO_PW-1:0] plo [4];
	logic signed [HI_PW-1:0] phi [4];

	always_comb begin
		re_ext = EXT_W'(re_s1);
		im_ext = EXT_W'(im_s1);
		// lanes: re*cr, im*ci, re*ci, im*cr
		a_lane[0] = re_ext;
		a_lane[1] = im_ext;
		a_lane[2] = re_ext;
		a_lane[3] = im_ext;
		c_lane[0] = cr_s1;
		c_lane[1] = ci_s1;
		c_lane[2] = ci_s1;
		c_lane[3] = cr_s1;
		for (int l = 0; l < 4; l++) begin
			plo[l] = $signed({1'b0, a_lane[l][FRAC-1:0]}) * c_lane[l];
			phi[l] = $signed(a_lane[l][EXT_W-1:FRAC]) * c_lane[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			basis_s2 <= basis_s1;
			alt_s2   <= alt_s1;
			ctl_s2   <= ctl_s1;
			for (int l = 0; l < 4; l++) begin
				plo_s2[l] <= plo[l];
				phi_s2[l] <= phi[l];
			end
		end
	end

	// stage 3: rounded real products
	logic signed [LO_PW-1:0] rnd [4];
	logic signed [LO_PW-1:0] rnd_sh [4];
	logic signed [PW-1:0]    prod [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			rnd[l]    = plo_s2[l] + RND_HALF;
			rnd_sh[l] = rnd[l] >>> FRAC;
			prod[l]   = PW'(phi_s2[l]) + PW'(rnd_sh[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			basis_s3 <= basis_s2;
			alt_s3   <= alt_s2;
			ctl_s3   <= ctl_s2;
			for (int l = 0; l < 4; l++) begin
				prod_s3[l] <= prod[l];
			end
		end
	end

	// output stage: complex sum, saturation, hadamard sign
	logic signed [SW-1:0]       sum_re, sum_im;
	logic signed [AMP_BITS-1:0] sat_re, sat_im, first_re, first_im;

	always_comb begin
		sum_re = SW'(prod_s3[0]) - SW'(prod_s3[1]);
		sum_im = SW'(prod_s3[2]) + SW'(prod_s3[3]);
		priority if (sum_re > SAT_HI) begin
			sat_re = AMP_MAX;
		end else if (sum_re < SAT_LO) begin
			sat_re = AMP_MIN;
		end else begin
			sat_re = sum_re[AMP_BITS-1:0];
		end
		priority if (sum_im > SAT_HI) begin
			sat_im = AMP_MAX;
		end else if (sum_im < SAT_LO) begin
			sat_im = AMP_MIN;
		end else begin
			sat_im = sum_im[AMP_BITS-1:0];
		end
		first_re = sat_re;
		first_im = sat_im;
		if (ctl_s3.neg) begin
			first_re = (sat_re == AMP_MIN) ? AMP_MAX : -sat_re;
			first_im = (sat_im == AMP_MIN) ? AMP_MAX : -sat_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s3;
			pend_q      <= valid_s3 && ctl_s3.dual;
		end else if (m_tready && pend_q) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s3) begin
			basis_q  <= basis_s3;
			re_q     <= first_re;
			im_q     <= first_im;
			last_q   <= !ctl_s3.dual;
			basis2_q <= alt_s3;
			re2_q    <= sat_re;
			im2_q    <= sat_im;
		end else if (!out_en && m_tready && pend_q) begin
			basis_q <= basis2_q;
			re_q    <= re2_q;
			im_q    <= im2_q;
			last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = OUT_TW'({im_q, re_q, 64'(basis_q)});

endmodule

`default_nettype wire

// File: src/qgb_decode.sv
// ----------------------------------------------------------------------------
// qgb_decode: gate decode
// Builds qubit masks, tests the basis bits, picks the new basis pattern and
// the complex coefficient that the amplitude is multiplied by.
// ----------------------------------------------------------------------------
`default_nettype none

module qgb_decode #(
	parameter int QUBITS    = qgb_pkg::QUBITS_DEF,
	parameter int ROT_K_MAX = qgb_pkg::ROT_K_MAX_DEF
) (
	input  logic [3:0]                              func,
	input  logic [5:0]                              qubit_a,
	input  logic [5:0]                              qubit_b,
	input  logic [5:0]                              qubit_c,
	input  logic [5:0]                              rot_order,
	input  logic [QUBITS-1:0]                       basis,
	output logic [QUBITS-1:0]                       basis_out,
	output logic [QUBITS-1:0]                       basis_alt,
	output logic signed [qgb_pkg::COEF_W-1:0]       coef_re,
	output logic signed [qgb_pkg::COEF_W-1:0]       coef_im,
	output qgb_pkg::qgb_ctl_t                       ctl
);

	localparam int KI_W = $clog2(ROT_K_MAX + 1);
	localparam int CW   = qgb_pkg::COEF_W;

	logic [2*CW-1:0] rom [ROT_K_MAX+1];

	for (genvar g = 0; g <= ROT_K_MAX; g++) begin : g_rom
		localparam logic [2*CW-1:0] ENTRY = qgb_pkg::rot_entry(g);
		assign rom[g] = ENTRY;
	end

	logic [QUBITS-1:0] ma, mb, mc, mab, mbc;
	logic [6:0]        k_clamp;
	logic [KI_W-1:0]   k_idx;
	logic [2*CW-1:0]   rot;
	logic              ta, tb, all_ab, swap_ab, fred;

	always_comb begin
		ma = ({1'b0, qubit_a} < 7'(QUBITS)) ? (QUBITS'(1) << qubit_a) : '0;
		mb = ({1'b0, qubit_b} < 7'(QUBITS)) ? (QUBITS'(1) << qubit_b) : '0;
		mc = ({1'b0, qubit_c} < 7'(QUBITS)) ? (QUBITS'(1) << qubit_c) : '0;
		mab = ma | mb;
		mbc = mb | mc;
		ta = |(basis & ma);
		tb = |(basis & mb);
		all_ab = ((basis & mab) == mab);
		swap_ab = (|(basis & mab)) && (|(~basis & mab));
		fred = ((basis & ma) == ma) && (|(basis & mbc)) && (|(~basis & mbc));

		k_clamp = {1'b0, rot_order};
		if (k_clamp == 7'd0) begin
			k_clamp = 7'd1;
		end
		if (k_clamp > 7'(ROT_K_MAX)) begin
			k_clamp = 7'(ROT_K_MAX);
		end
		k_idx = k_clamp[KI_W-1:0];
		rot = rom[k_idx];
	end

	always_comb begin
		basis_out = basis;
		basis_alt = basis ^ ma;
		coef_re = qgb_pkg::COEF_ONE;
		coef_im = qgb_pkg::COEF_ZERO;
		ctl = '0;
		unique case (qgb_pkg::gate_t'(func))
			qgb_pkg::GATE_H: begin
				coef_re = qgb_pkg::COEF_INV_SQRT2;
				ctl.dual = 1'b1;
				ctl.neg = ta;
			end
			qgb_pkg::GATE_X: begin
				basis_out = basis ^ ma;
			end
			qgb_pkg::GATE_Y: begin
				coef_re = qgb_pkg::COEF_ZERO;
				coef_im = ta ? qgb_pkg::COEF_NEG_ONE : qgb_pkg::COEF_ONE;
				basis_out = basis ^ ma;
			end
			qgb_pkg::GATE_Z: begin
				if (ta) begin
					coef_re = qgb_pkg::COEF_NEG_ONE;
				end
			end
			qgb_pkg::GATE_S: begin
				if (ta) begin
					coef_re = qgb_pkg::COEF_ZERO;
					coef_im = qgb_pkg::COEF_ONE;
				end
			end
			qgb_pkg::GATE_T: begin
				if (ta) begin
					coef_re = qgb_pkg::COEF_INV_SQRT2;
					coef_im = qgb_pkg::COEF_INV_SQRT2;
				end
			end
			qgb_pkg::GATE_RK: begin
				if (ta) begin
					coef_re = signed'(rot[2*CW-1:CW]);
					coef_im = signed'(rot[CW-1:0]);
				end
			end
			qgb_pkg::GATE_SWAP: begin
				if (swap_ab) begin
					basis_out = basis ^ mab;
				end
			end
			qgb_pkg::GATE_CX: begin
				if (ta) begin
					basis_out = basis ^ mb;
				end
			end
			qgb_pkg::GATE_CY: begin
				if (ta) begin
					coef_re = qgb_pkg::COEF_ZERO;
					coef_im = tb ? qgb_pkg::COEF_NEG_ONE : qgb_pkg::COEF_ONE;
					basis_out = basis ^ mb;
				end
			end
			qgb_pkg::GATE_CZ: begin
				if (all_ab) begin
					coef_re = qgb_pkg::COEF_NEG_ONE;
				end
			end
			qgb_pkg::GATE_CS: begin
				if (all_ab) begin
					coef_re = qgb_pkg::COEF_ZERO;
					coef_im = qgb_pkg::COEF_ONE;
				end
			end
			qgb_pkg::GATE_CRK: begin
				if (all_ab) begin
					coef_re = signed'(rot[2*CW-1:CW]);
					coef_im = signed'(rot[CW-1:0]);
				end
			end
			qgb_pkg::GATE_TOFFOLI: begin
				if (all_ab) begin
					basis_out = basis ^ mc;
				end
			end
			qgb_pkg::GATE_FREDKIN: begin
				if (fred) begin
					basis_out = basis ^ mbc;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sparse register gate unit, self-checking stream test
// Streams register entries through every gate code, predicts the updated
// entries with an independent fixed-point model (including the rotation
// series) and checks each returned entry field by field, in order, under
// random idling on both stream sides and then in a last run with no idling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0]  FUNC_PASS  = 4'd15;
	localparam logic [31:0] AMP_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0] AMP_MIN    = 32'h8000_0000;
	localparam logic [63:0] BASIS_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint      Q30_ONE    = 64'sd1073741824;
	localparam longint      Q30_HALF_R = 64'sd759250125;
	localparam logic [63:0] QUARTER_PI = 64'hC90F_DAA2_2168_C235;
	localparam int          TAIL_CYCLES = 24;
	localparam int          PRINT_CAP   = 30;

	// s_tdata, lowest bit up: func, qubit_a, qubit_b, qubit_c, rot_order,
	// basis_in, amp_re_in, amp_im_in, zero fill
	typedef struct packed {
		logic [3:0]  fill;
		logic [31:0] amp_im;
		logic [31:0] amp_re;
		logic [63:0] basis;
		logic [5:0]  rot_order;
		logic [5:0]  qubit_c;
		logic [5:0]  qubit_b;
		logic [5:0]  qubit_a;
		logic [3:0]  func;
	} gate_item_t;

	// m_tdata, lowest bit up: basis_out, amp_re_out, amp_im_out
	typedef struct packed {
		logic [31:0] amp_im;
		logic [31:0] amp_re;
		logic [63:0] basis;
	} reg_entry_t;

	typedef struct packed {
		logic       last;
		reg_entry_t entry;
	} tagged_entry_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         m_tlast;

	gate_item_t    pending_items[$];
	tagged_entry_t updated_entries[$];
	int            send_idle_pct;
	int            recv_idle_pct;
	int            mismatches;
	int            items_taken;
	int            entries_checked;
	int            hadamard_pairs;
	int            gate_seen[16];

	quantum_gate_basis_amplitude_update_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
	endtask

	function automatic longint clip_amp(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// round half up of a * c / 2^30
	function automatic longint scale_q30(input longint a, input longint c);
		return (a * c + 64'sd536870912) >>> 30;
	endfunction

	task automatic rotate_amp(inout longint re, inout longint im,
			input longint cr, input longint ci);
		longint r;
		longint i;
		r = clip_amp(scale_q30(re, cr) - scale_q30(im, ci));
		i = clip_amp(scale_q30(re, ci) + scale_q30(im, cr));
		re = r;
		im = i;
	endtask

	// cos/sin of pi/2^(k-1) from truncated taylor series in q0.64
	task automatic phase_coef(input int k, output longint cr, output longint ci);
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  t;
		logic [63:0]  s_acc;
		logic [63:0]  c_acc;
		logic [127:0] p;
		if (k == 1) begin
			cr = -Q30_ONE;
			ci = 0;
		end else if (k == 2) begin
			cr = 0;
			ci = Q30_ONE;
		end else begin
			x = QUARTER_PI >> (k - 3);
			p = 128'(x) * 128'(x);
			x2 = p[127:64];
			t = x;
			s_acc = x;
			for (int n = 1; n <= 12; n++) begin
				p = 128'(t) * 128'(x2);
				t = p[127:64] / 64'(2 * n * (2 * n + 1));
				if (n % 2 == 1) begin
					s_acc = s_acc - t;
				end else begin
					s_acc = s_acc + t;
				end
			end
			t = x2 >> 1;
			c_acc = t;
			for (int n = 2; n <= 13; n++) begin
				p = 128'(t) * 128'(x2);
				t = p[127:64] / 64'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					c_acc = c_acc + t;
				end else begin
					c_acc = c_acc - t;
				end
			end
			ci = longint'((s_acc + 64'h2_0000_0000) >> 34);
			cr = Q30_ONE - longint'((c_acc + 64'h2_0000_0000) >> 34);
		end
	endtask

	task automatic store_entry(input logic [63:0] b, input longint re, input longint im,
			input logic last);
		tagged_entry_t e;
		e.last = last;
		e.entry.basis = b;
		e.entry.amp_re = re[31:0];
		e.entry.amp_im = im[31:0];
		updated_entries.push_back(e);
	endtask

	task automatic apply_gate(input gate_item_t it);
		logic [63:0] b;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] mc;
		logic [63:0] m;
		longint      re;
		longint      im;
		longint      tmp;
		longint      cr;
		longint      ci;
		int          k;
		b = it.basis;
		ma = 64'd1 << it.qubit_a;
		mb = 64'd1 << it.qubit_b;
		mc = 64'd1 << it.qubit_c;
		re = longint'(signed'(it.amp_re));
		im = longint'(signed'(it.amp_im));
		k = int'(it.rot_order);
		if (k == 0) begin
			k = 1;
		end
		if (k > 32) begin
			k = 32;
		end
		gate_seen[it.func]++;
		case (it.func)
			qgb_pkg::GATE_H: begin
				re = clip_amp(scale_q30(re, Q30_HALF_R));
				im = clip_amp(scale_q30(im, Q30_HALF_R));
				if ((b & ma) != 0) begin
					store_entry(b, clip_amp(-re), clip_amp(-im), 1'b0);
				end else begin
					store_entry(b, re, im, 1'b0);
				end
				store_entry(b ^ ma, re, im, 1'b1);
				hadamard_pairs++;
				return;
			end
			qgb_pkg::GATE_X: b ^= ma;
			qgb_pkg::GATE_Y, qgb_pkg::GATE_CY: begin
				m = (it.func == qgb_pkg::GATE_Y) ? ma : mb;
				if (it.func == qgb_pkg::GATE_Y || (b & ma) != 0) begin
					tmp = re;
					if ((b & m) != 0) begin
						re = im;
						im = clip_amp(-tmp);
					end else begin
						re = clip_amp(-im);
						im = tmp;
					end
					b ^= m;
				end
			end
			qgb_pkg::GATE_Z: begin
				if ((b & ma) != 0) begin
					re = clip_amp(-re);
					im = clip_amp(-im);
				end
			end
			qgb_pkg::GATE_S: begin
				if ((b & ma) != 0) begin
					tmp = re;
					re = clip_amp(-im);
					im = tmp;
				end
			end
			qgb_pkg::GATE_T: begin
				if ((b & ma) != 0) begin
					rotate_amp(re, im, Q30_HALF_R, Q30_HALF_R);
				end
			end
			qgb_pkg::GATE_RK: begin
				if ((b & ma) != 0) begin
					phase_coef(k, cr, ci);
					rotate_amp(re, im, cr, ci);
				end
			end
			qgb_pkg::GATE_SWAP: begin
				m = ma | mb;
				if ((b & m) != 0 && (~b & m) != 0) begin
					b ^= m;
				end
			end
			qgb_pkg::GATE_CX: begin
				if ((b & ma) != 0) begin
					b ^= mb;
				end
			end
			qgb_pkg::GATE_CZ: begin
				m = ma | mb;
				if ((b & m) == m) begin
					re = clip_amp(-re);
					im = clip_amp(-im);
				end
			end
			qgb_pkg::GATE_CS: begin
				m = ma | mb;
				if ((b & m) == m) begin
					tmp = re;
					re = clip_amp(-im);
					im = tmp;
				end
			end
			qgb_pkg::GATE_CRK: begin
				m = ma | mb;
				if ((b & m) == m) begin
					phase_coef(k, cr, ci);
					rotate_amp(re, im, cr, ci);
				end
			end
			qgb_pkg::GATE_TOFFOLI: begin
				m = ma | mb;
				if ((b & m) == m) begin
					b ^= mc;
				end
			end
			qgb_pkg::GATE_FREDKIN: begin
				m = mb | mc;
				if ((b & ma) != 0 && (b & m) != 0 && (~b & m) != 0) begin
					b ^= m;
				end
			end
			default: ;
		endcase
		store_entry(b, re, im, 1'b1);
	endtask

	task automatic add_item(input logic [3:0] func, input int qa, input int qb, input int qc,
			input int k, input logic [63:0] basis, input logic [31:0] re,
			input logic [31:0] im);
		gate_item_t it;
		it = '0;
		it.func = func;
		it.qubit_a = 6'(qa);
		it.qubit_b = 6'(qb);
		it.qubit_c = 6'(qc);
		it.rot_order = 6'(k);
		it.basis = basis;
		it.amp_re = re;
		it.amp_im = im;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_amp();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: return AMP_MIN;
			1: return AMP_MAX;
			2: return {{22{v[31]}}, v[9:0]};
			default: return v;
		endcase
	endfunction

	function automatic int pick_qubit();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 63;
			default: return $urandom_range(0, 63);
		endcase
	endfunction

	task automatic add_random_items(input int count);
		int          qa;
		int          qb;
		int          qc;
		int          k;
		logic [3:0]  func;
		logic [63:0] basis;
		for (int n = 0; n < count; n++) begin
			func = 4'($urandom_range(0, 15));
			qa = pick_qubit();
			qb = ($urandom_range(0, 9) == 0) ? qa : pick_qubit();
			qc = ($urandom_range(0, 9) == 0) ? qb : pick_qubit();
			case ($urandom_range(0, 9))
				0: k = 0;
				1: k = $urandom_range(33, 63);
				default: k = $urandom_range(1, 32);
			endcase
			basis = {$urandom, $urandom};
			// mostly satisfy the controls so the gates actually act
			if ($urandom_range(0, 3) != 0) begin
				basis = basis | (64'd1 << qa) | (64'd1 << qb);
			end
			if (func == qgb_pkg::GATE_FREDKIN && $urandom_range(0, 1) == 1) begin
				basis = (basis | (64'd1 << qa) | (64'd1 << qb)) & ~(64'd1 << qc);
			end
			add_item(func, qa, qb, qc, k, basis, pick_amp(), pick_amp());
		end
	endtask

	task automatic drain_items();
		while (pending_items.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_items.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		reg_entry_t    got;
		tagged_entry_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_gate(gate_item_t'(s_tdata));
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = reg_entry_t'(m_tdata);
				if (updated_entries.size() == 0) begin
					flag_mismatch($sformatf("entry %h with none pending", m_tdata));
				end else begin
					want = updated_entries.pop_front();
					entries_checked++;
					if (got.basis !== want.entry.basis) begin
						flag_mismatch($sformatf("basis %h, want %h",
							got.basis, want.entry.basis));
					end
					if (got.amp_re !== want.entry.amp_re) begin
						flag_mismatch($sformatf("amp_re %h, want %h (basis %h)",
							got.amp_re, want.entry.amp_re, want.entry.basis));
					end
					if (got.amp_im !== want.entry.amp_im) begin
						flag_mismatch($sformatf("amp_im %h, want %h (basis %h)",
							got.amp_im, want.entry.amp_im, want.entry.basis));
					end
					if (m_tlast !== want.last) begin
						flag_mismatch($sformatf("tlast %b, want %b (basis %h)",
							m_tlast, want.last, want.entry.basis));
					end
				end
			end
		end
	end

	initial begin
		int codes_hit;
		send_idle_pct = 6;
		recv_idle_pct = 48;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(qgb_pkg::GATE_H, 0, 0, 0, 1, 64'd0, AMP_MAX, AMP_MIN);
		add_item(qgb_pkg::GATE_H, 63, 0, 0, 1, BASIS_ONES, AMP_MIN, AMP_MAX);
		add_item(qgb_pkg::GATE_X, 63, 0, 0, 1, 64'd0, 32'd12345, 32'd54321);
		add_item(qgb_pkg::GATE_Y, 5, 0, 0, 1, 64'd0, AMP_MIN, AMP_MIN);
		add_item(qgb_pkg::GATE_Y, 5, 0, 0, 1, 64'd1 << 5, AMP_MIN, 32'd3);
		add_item(qgb_pkg::GATE_Z, 0, 0, 0, 1, 64'd1, AMP_MIN, AMP_MAX);
		add_item(qgb_pkg::GATE_S, 1, 0, 0, 1, 64'd2, 32'd7, AMP_MIN);
		add_item(qgb_pkg::GATE_T, 2, 0, 0, 1, 64'd4, AMP_MAX, AMP_MAX);
		add_item(qgb_pkg::GATE_T, 2, 0, 0, 1, 64'd0, AMP_MAX, AMP_MIN);
		add_item(qgb_pkg::GATE_RK, 3, 0, 0, 0, 64'd8, 32'd12345, -32'sd6789);
		add_item(qgb_pkg::GATE_RK, 3, 0, 0, 2, BASIS_ONES, AMP_MAX, AMP_MIN);
		add_item(qgb_pkg::GATE_RK, 3, 0, 0, 3, BASIS_ONES, AMP_MAX, AMP_MAX);
		add_item(qgb_pkg::GATE_RK, 63, 0, 0, 32, BASIS_ONES, AMP_MIN, 32'd1000);
		add_item(qgb_pkg::GATE_RK, 63, 0, 0, 63, BASIS_ONES, AMP_MIN, AMP_MIN);
		add_item(qgb_pkg::GATE_SWAP, 4, 9, 0, 1, 64'd1 << 4, 32'd1, 32'd2);
		add_item(qgb_pkg::GATE_SWAP, 4, 4, 0, 1, 64'd1 << 4, 32'd1, 32'd2);
		add_item(qgb_pkg::GATE_CX, 0, 63, 0, 1, 64'd1, 32'd5, 32'd6);
		add_item(qgb_pkg::GATE_CY, 0, 1, 0, 1, 64'd3, AMP_MIN, 32'd9);
		add_item(qgb_pkg::GATE_CZ, 6, 6, 0, 1, 64'd1 << 6, AMP_MIN, AMP_MIN);
		add_item(qgb_pkg::GATE_CS, 7, 8, 0, 1, BASIS_ONES, AMP_MAX, AMP_MIN);
		add_item(qgb_pkg::GATE_CRK, 10, 11, 0, 4, BASIS_ONES, AMP_MAX, AMP_MAX);
		add_item(qgb_pkg::GATE_TOFFOLI, 1, 2, 3, 1, 64'd6, 32'd11, 32'd22);
		add_item(qgb_pkg::GATE_TOFFOLI, 12, 12, 12, 1, 64'd1 << 12, 32'd33, 32'd44);
		add_item(qgb_pkg::GATE_FREDKIN, 0, 1, 2, 1, 64'd3, 32'd55, 32'd66);
		add_item(FUNC_PASS, 9, 9, 9, 9, {$urandom, $urandom}, AMP_MIN, AMP_MAX);
		add_random_items(360);
		drain_items();

		send_idle_pct = 48;
		recv_idle_pct = 6;
		add_random_items(385);
		drain_items();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_items(385);
		drain_items();

		while (updated_entries.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		codes_hit = 0;
		foreach (gate_seen[i]) begin
			if (gate_seen[i] != 0) begin
				codes_hit++;
			end
		end
		$display("covered %0d items over %0d of 16 gate codes, %0d entries compared",
			items_taken, codes_hit, entries_checked);
		$display("hadamard pairs %0d, field mismatches %0d", hadamard_pairs, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
